// File: rtl/lrbc_pkg.sv
package lrbc_pkg;

   // Field widths
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned InitialWidth = 30;
   localparam int unsigned DelayWidth   = 31;
   localparam int unsigned LevelWidth   = 8;
   localparam int unsigned BarsWidth    = 2;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 32;

   // Register reset values
   localparam logic [TimeWidth-1:0]    ResetConnectTimeout = 32'd12000;
   localparam logic [InitialWidth-1:0] ResetInitialBackoff = 30'd30000;
   localparam logic [DelayWidth-1:0]   ResetMaxBackoff     = 31'd1800000;
   localparam logic [LevelWidth-1:0]   ResetStrongLevel    = 8'hC9;
   localparam logic [LevelWidth-1:0]   ResetFairLevel      = 8'hBA;

   // Strength classes
   localparam logic [BarsWidth-1:0] BarsNone   = 2'd0;
   localparam logic [BarsWidth-1:0] BarsWeak   = 2'd1;
   localparam logic [BarsWidth-1:0] BarsFair   = 2'd2;
   localparam logic [BarsWidth-1:0] BarsStrong = 2'd3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CONNECT_TIMEOUT = 3'd0,
      CSR_INITIAL_BACKOFF = 3'd1,
      CSR_MAX_BACKOFF     = 3'd2,
      CSR_STRONG_LEVEL    = 3'd3,
      CSR_FAIR_LEVEL      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0]         now_ms;
      logic                         link_up;
      logic signed [LevelWidth-1:0] signal_level;
   } req_payload_type;

   typedef struct packed {
      logic                  connected;
      logic [BarsWidth-1:0]  signal_bars;
      logic                  newly_connected;
      logic                  link_lost;
      logic                  start_attempt;
      logic                  abort_attempt;
      logic [DelayWidth-1:0] retry_delay_ms;
   } rsp_payload_type;

endpackage

// File: rtl/lrbc_chan_if.sv
interface lrbc_req_if;
   logic                      valid;
   logic                      ready;
   lrbc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lrbc_rsp_if;
   logic                      valid;
   logic                      ready;
   lrbc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/link_retry_backoff_controller.sv
// Link retry controller with exponential backoff.
// req_chan: one service tick per transfer (now_ms, link_up, signal_level).
// rsp_chan: exactly one result per tick, in order (link status, bar count,
//   connect/lost events, start/abort pulses for the radio, retry delay used).
// csr_*: plain write port for the five timing and level registers; write
//   only while no tick is in flight.
// A req transfer reaches rsp_chan through the input register, then the
//   result register. Throughput: one tick per cycle while rsp_chan does not
//   stall; the combinational path is one 32-bit subtract/compare for the
//   timeout, one for the schedule check and one add for the next attempt time.
// Reset (synchronous, active high) empties both stages, restores register
//   defaults and returns to idle: no schedule, no attempt, delay at the
//   initial backoff. The first down tick then starts an attempt.
// When rsp_chan stalls, the result register holds and one more tick waits
//   in the input register; req_chan.ready then drops until the result moves.
module link_retry_backoff_controller (
   input  logic                                    clock,
   input  logic                                    reset,
   lrbc_req_if.sink                                req_chan,
   lrbc_rsp_if.source                              rsp_chan,
   input  logic                                    csr_write_en,
   input  logic [lrbc_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [lrbc_pkg::CsrDataWidth-1:0]       csr_wdata
);

   // Configuration registers
   logic [lrbc_pkg::TimeWidth-1:0]           timeout_ff;
   logic [lrbc_pkg::InitialWidth-1:0]        initial_ff;
   logic [lrbc_pkg::DelayWidth-1:0]          max_ff;
   logic signed [lrbc_pkg::LevelWidth-1:0]   strong_ff;
   logic signed [lrbc_pkg::LevelWidth-1:0]   fair_ff;

   // Pipeline registers
   logic                       s1_valid_ff, s1_valid_in;
   lrbc_pkg::req_payload_type  s1_data_ff;
   logic                       out_valid_ff, out_valid_in;
   lrbc_pkg::rsp_payload_type  out_data_ff, out_next;

   // Controller state
   logic                              was_up_ff, was_up_in;
   logic                              running_ff, running_in;
   logic                              sched_valid_ff, sched_valid_in;
   logic [lrbc_pkg::TimeWidth-1:0]    start_time_ff, start_time_in;
   logic [lrbc_pkg::TimeWidth-1:0]    next_time_ff, next_time_in;
   logic [lrbc_pkg::DelayWidth-1:0]   delay_ff, delay_in;

   // Datapath
   logic                              req_xfer, out_load;
   logic [lrbc_pkg::TimeWidth-1:0]    elapsed, wait_diff, sched_time, doubled;
   logic                              timed_out, due;
   logic [lrbc_pkg::DelayWidth-1:0]   capped;

   // ---------------------------------------------------------------- handshake
   // Advance the input stage when the result register is empty or draining.
   assign out_load       = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || out_load;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_chan.payload;
      end
      if (out_load) begin
         out_data_ff <= out_next;
      end
   end

   // ---------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= lrbc_pkg::ResetConnectTimeout;
         initial_ff <= lrbc_pkg::ResetInitialBackoff;
         max_ff     <= lrbc_pkg::ResetMaxBackoff;
         strong_ff  <= lrbc_pkg::ResetStrongLevel;
         fair_ff    <= lrbc_pkg::ResetFairLevel;
      end else if (csr_write_en) begin
         case (lrbc_pkg::csr_index_type'(csr_index))
            lrbc_pkg::CSR_CONNECT_TIMEOUT: begin
               timeout_ff <= csr_wdata[lrbc_pkg::TimeWidth-1:0];
            end
            lrbc_pkg::CSR_INITIAL_BACKOFF: begin
               initial_ff <= csr_wdata[lrbc_pkg::InitialWidth-1:0];
            end
            lrbc_pkg::CSR_MAX_BACKOFF: begin
               max_ff <= csr_wdata[lrbc_pkg::DelayWidth-1:0];
            end
            lrbc_pkg::CSR_STRONG_LEVEL: begin
               strong_ff <= csr_wdata[lrbc_pkg::LevelWidth-1:0];
            end
            lrbc_pkg::CSR_FAIR_LEVEL: begin
               fair_ff <= csr_wdata[lrbc_pkg::LevelWidth-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------- tick datapath
   // Time differences are modulo 2^32; the schedule check uses the sign bit
   // of the difference so it survives clock wrap.
   assign elapsed    = s1_data_ff.now_ms - start_time_ff;
   assign timed_out  = (elapsed >= timeout_ff);
   assign wait_diff  = s1_data_ff.now_ms - next_time_ff;
   assign due        = !sched_valid_ff || !wait_diff[lrbc_pkg::TimeWidth-1];
   assign sched_time = s1_data_ff.now_ms + {1'b0, delay_ff};
   // Double the delay and cap it; the doubled value needs the full 32 bits.
   assign doubled    = {delay_ff, 1'b0};
   assign capped     = (doubled < {1'b0, max_ff}) ?
                       doubled[lrbc_pkg::DelayWidth-1:0] : max_ff;

   always_comb begin
      out_next       = '0;
      was_up_in      = was_up_ff;
      running_in     = running_ff;
      sched_valid_in = sched_valid_ff;
      start_time_in  = start_time_ff;
      next_time_in   = next_time_ff;
      delay_in       = delay_ff;

      if (s1_data_ff.link_up) begin
         // Link up: report, classify strength, restore the initial backoff.
         out_next.connected = 1'b1;
         if (s1_data_ff.signal_level >= strong_ff) begin
            out_next.signal_bars = lrbc_pkg::BarsStrong;
         end else if (s1_data_ff.signal_level >= fair_ff) begin
            out_next.signal_bars = lrbc_pkg::BarsFair;
         end else begin
            out_next.signal_bars = lrbc_pkg::BarsWeak;
         end
         out_next.newly_connected = !was_up_ff;
         was_up_in  = 1'b1;
         running_in = 1'b0;
         delay_in   = {1'b0, initial_ff};
      end else begin
         out_next.signal_bars = lrbc_pkg::BarsNone;
         if (was_up_ff) begin
            // First down tick: schedule the next attempt one delay ahead.
            out_next.link_lost      = 1'b1;
            out_next.retry_delay_ms = delay_ff;
            was_up_in      = 1'b0;
            next_time_in   = sched_time;
            sched_valid_in = 1'b1;
         end
         if (running_ff) begin
            // Attempt in flight: abort on timeout, reschedule, back off.
            if (timed_out) begin
               out_next.abort_attempt  = 1'b1;
               out_next.retry_delay_ms = delay_ff;
               running_in     = 1'b0;
               next_time_in   = sched_time;
               sched_valid_in = 1'b1;
               delay_in       = capped;
            end
         end else if (was_up_ff ? (delay_ff == '0) : due) begin
            // A schedule made on this very tick is due only for a zero delay.
            out_next.start_attempt = 1'b1;
            start_time_in = s1_data_ff.now_ms;
            running_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_up_ff      <= 1'b0;
         running_ff     <= 1'b0;
         sched_valid_ff <= 1'b0;
         start_time_ff  <= '0;
         next_time_ff   <= '0;
         delay_ff       <= {1'b0, lrbc_pkg::ResetInitialBackoff};
      end else if (out_load) begin
         was_up_ff      <= was_up_in;
         running_ff     <= running_in;
         sched_valid_ff <= sched_valid_in;
         start_time_ff  <= start_time_in;
         next_time_ff   <= next_time_in;
         delay_ff       <= delay_in;
      end
   end

   // ------------------------------------------------------------- assertions
   // An up tick always leaves no attempt running.
   a_up_clears_attempt: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_next.connected) |=> !running_ff)
      else $error("attempt still running after an up tick");

   // A started attempt is recorded with the tick's time.
   a_start_records_time: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_next.start_attempt) |=>
         (running_ff && (start_time_ff == $past(s1_data_ff.now_ms))))
      else $error("attempt start not recorded");

   // A tick waiting behind a stalled result stays in the input stage.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input stage lost a waiting tick");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // Watchdog: cycles in a row with no transfer on either channel
   localparam int unsigned QuietLimit = 1000;

   logic clock;
   logic reset;
   logic                              csr_write_en;
   logic [lrbc_pkg::CsrIdxWidth-1:0]  csr_index;
   logic [lrbc_pkg::CsrDataWidth-1:0] csr_wdata;

   lrbc_req_if req_if ();
   lrbc_rsp_if rsp_if ();

   link_retry_backoff_controller dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Link status predictor: own copy of registers and retry state
   // ------------------------------------------------------------------
   logic [31:0]                       lim_timeout = lrbc_pkg::ResetConnectTimeout;
   logic [lrbc_pkg::InitialWidth-1:0] lim_initial = lrbc_pkg::ResetInitialBackoff;
   logic [lrbc_pkg::DelayWidth-1:0]   lim_cap     = lrbc_pkg::ResetMaxBackoff;
   logic signed [7:0]                 lvl_strong  = lrbc_pkg::ResetStrongLevel;
   logic signed [7:0]                 lvl_fair    = lrbc_pkg::ResetFairLevel;

   logic        seen_up      = 1'b0;
   logic        attempt_live = 1'b0;
   logic [31:0] attempt_t0   = '0;
   logic [31:0] next_try_ms  = '0;
   logic [31:0] backoff_ms   = 32'd30000;
   logic        schedule_set = 1'b0;

   // Expected link status, one entry per accepted tick, oldest first
   lrbc_pkg::rsp_payload_type pending_status[$];

   int failures = 0;

   function automatic lrbc_pkg::rsp_payload_type predict_tick(
      input lrbc_pkg::req_payload_type t);
      lrbc_pkg::rsp_payload_type r;
      logic [31:0] elapsed;
      logic [31:0] diff;
      logic [32:0] doubled;
      logic        busy;
      r = '0;
      busy = 1'b0;
      if (t.link_up) begin
         r.connected = 1'b1;
         // strong is tested first, so crossed levels favor three bars
         if ($signed(t.signal_level) >= lvl_strong) begin
            r.signal_bars = lrbc_pkg::BarsStrong;
         end else if ($signed(t.signal_level) >= lvl_fair) begin
            r.signal_bars = lrbc_pkg::BarsFair;
         end else begin
            r.signal_bars = lrbc_pkg::BarsWeak;
         end
         r.newly_connected = !seen_up;
         seen_up = 1'b1;
         attempt_live = 1'b0;
         backoff_ms = {2'b00, lim_initial};
      end else begin
         if (seen_up) begin
            // first down tick: schedule the next attempt one delay ahead
            r.link_lost = 1'b1;
            seen_up = 1'b0;
            next_try_ms = t.now_ms + backoff_ms;
            schedule_set = 1'b1;
            r.retry_delay_ms = backoff_ms[lrbc_pkg::DelayWidth-1:0];
         end
         if (attempt_live) begin
            busy = 1'b1;
            elapsed = t.now_ms - attempt_t0;
            if (elapsed >= lim_timeout) begin
               // abort, reschedule with the current delay, then double it
               r.abort_attempt = 1'b1;
               attempt_live = 1'b0;
               next_try_ms = t.now_ms + backoff_ms;
               schedule_set = 1'b1;
               r.retry_delay_ms = backoff_ms[lrbc_pkg::DelayWidth-1:0];
               doubled = {1'b0, backoff_ms} << 1;
               backoff_ms = (doubled < {2'b00, lim_cap}) ? doubled[31:0] : {1'b0, lim_cap};
            end
         end
         if (!busy) begin
            // wrap-safe: start once now is at or past the schedule
            diff = t.now_ms - next_try_ms;
            if (!schedule_set || !diff[31]) begin
               r.start_attempt = 1'b1;
               attempt_t0 = t.now_ms;
               attempt_live = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Directed plan: ticks and register writes, walked in order
   // ------------------------------------------------------------------
   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      lrbc_pkg::csr_index_type   reg_idx;
      logic [31:0]               wdata;
      lrbc_pkg::req_payload_type tick;
      logic                      has_status;
      lrbc_pkg::rsp_payload_type status;
   } plan_row_type;

   plan_row_type plan[$];

   task automatic plan_tick(input logic [31:0] now, input logic up,
                            input logic signed [7:0] level);
      plan_row_type row;
      row = '{ROW_TICK, lrbc_pkg::CSR_CONNECT_TIMEOUT, '0, '0, 1'b0, '0};
      row.tick = '{now, up, level};
      plan.push_back(row);
   endtask

   // tick whose status is read off directly rather than predicted
   task automatic plan_known(input logic [31:0] now, input logic up,
                             input logic signed [7:0] level,
                             input logic conn, input logic [1:0] bars,
                             input logic newly, input logic lost,
                             input logic start, input logic abort_now,
                             input logic [30:0] delay);
      plan_row_type row;
      row = '{ROW_TICK, lrbc_pkg::CSR_CONNECT_TIMEOUT, '0, '0, 1'b1, '0};
      row.tick = '{now, up, level};
      row.status = '{conn, bars, newly, lost, start, abort_now, delay};
      plan.push_back(row);
   endtask

   task automatic plan_write(input lrbc_pkg::csr_index_type idx,
                             input logic [31:0] data);
      plan_row_type row;
      row = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
      plan.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // Drivers: every task starts and ends just after a rising edge
   // ------------------------------------------------------------------
   int unsigned burst_left = 0;
   logic        gaps_on = 1'b1;

   task automatic send_tick(input lrbc_pkg::req_payload_type p, input logic known,
                            input lrbc_pkg::rsp_payload_type status);
      lrbc_pkg::rsp_payload_type predicted;
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      // sample at the falling edge: the transfer lands on the next rising edge
      do @(negedge clock); while (!req_if.ready);
      predicted = predict_tick(p);
      pending_status.push_back(known ? status : predicted);
      @(posedge clock);
   endtask

   // Sender bursts: random lengths with random gaps between them
   task automatic pace();
      int unsigned gap;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         if (gaps_on) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Hold the sender until every expected status has come back
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input lrbc_pkg::csr_index_type idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         lrbc_pkg::CSR_CONNECT_TIMEOUT: lim_timeout = data;
         lrbc_pkg::CSR_INITIAL_BACKOFF: lim_initial = data[lrbc_pkg::InitialWidth-1:0];
         lrbc_pkg::CSR_MAX_BACKOFF:     lim_cap     = data[lrbc_pkg::DelayWidth-1:0];
         lrbc_pkg::CSR_STRONG_LEVEL:    lvl_strong  = data[7:0];
         lrbc_pkg::CSR_FAIR_LEVEL:      lvl_fair    = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Receiver: stall pattern picked by bits 9:8 of a free-running cycle count
   // ------------------------------------------------------------------
   logic [31:0] rx_cycle = '0;
   int unsigned hold_left = 0;

   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[9:8])
         2'd0: rsp_if.ready <= 1'b1;
         2'd1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
         2'd2: rsp_if.ready <= ((rx_cycle % 7) >= 3);
         default: begin
            if (hold_left != 0) begin
               rsp_if.ready <= 1'b0;
               hold_left <= hold_left - 1;
            end else begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) hold_left <= $urandom_range(1, 20);
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Checker: compare each result transfer with the oldest expectation
   // ------------------------------------------------------------------
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      lrbc_pkg::rsp_payload_type want;
      lrbc_pkg::rsp_payload_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_status.size() == 0) begin
            $error("result transfer with no tick waiting for it");
            failures++;
         end else begin
            want = pending_status.pop_front();
            check_field("connected", 32'(want.connected), 32'(got.connected));
            check_field("signal_bars", 32'(want.signal_bars), 32'(got.signal_bars));
            check_field("newly_connected", 32'(want.newly_connected),
                        32'(got.newly_connected));
            check_field("link_lost", 32'(want.link_lost), 32'(got.link_lost));
            check_field("start_attempt", 32'(want.start_attempt), 32'(got.start_attempt));
            check_field("abort_attempt", 32'(want.abort_attempt), 32'(got.abort_attempt));
            check_field("retry_delay_ms", 32'(want.retry_delay_ms),
                        32'(got.retry_delay_ms));
         end
      end
   end

   // Watchdog: drop the run when nothing moves for too long
   int unsigned quiet_cycles = 0;

   always @(negedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("link_retry_backoff_controller regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      lrbc_pkg::req_payload_type tick;
      logic        writing;
      logic        bold;
      logic        up_now;
      int unsigned run_left;
      int unsigned roll;
      int unsigned step_hi;
      int unsigned pick;
      logic [31:0] clk_ms;
      logic [31:0] t_val;
      logic [31:0] i_val;
      logic [31:0] m_val;
      logic [7:0]  s_val;
      logic [7:0]  f_val;

      // drive every input to a known value from time zero
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= lrbc_pkg::CSR_CONNECT_TIMEOUT;
      csr_wdata      <= '0;

      // idle after reset: the first down tick starts whatever now is
      plan_known(32'hFFFF_FFFF, 1'b0, 8'sh80, 1'b0, lrbc_pkg::BarsNone, 1'b0, 1'b0,
                 1'b1, 1'b0, 31'd0);
      // exactly the timeout across the wrap: abort with the initial delay
      plan_known(32'h0000_2EDF, 1'b0, 8'sd127, 1'b0, lrbc_pkg::BarsNone, 1'b0, 1'b0,
                 1'b0, 1'b1, 31'd30000);
      plan_tick(32'd41998, 1'b0, 8'sd0);
      plan_tick(32'd41999, 1'b0, 8'sd0);
      // bar thresholds at the reset levels
      plan_known(32'd42000, 1'b1, 8'sd127, 1'b1, lrbc_pkg::BarsStrong, 1'b1, 1'b0,
                 1'b0, 1'b0, 31'd0);
      plan_known(32'd42001, 1'b1, -8'sd55, 1'b1, lrbc_pkg::BarsStrong, 1'b0, 1'b0,
                 1'b0, 1'b0, 31'd0);
      plan_known(32'd42002, 1'b1, -8'sd56, 1'b1, lrbc_pkg::BarsFair, 1'b0, 1'b0,
                 1'b0, 1'b0, 31'd0);
      plan_known(32'd42003, 1'b1, -8'sd70, 1'b1, lrbc_pkg::BarsFair, 1'b0, 1'b0,
                 1'b0, 1'b0, 31'd0);
      plan_known(32'd42004, 1'b1, -8'sd71, 1'b1, lrbc_pkg::BarsWeak, 1'b0, 1'b0,
                 1'b0, 1'b0, 31'd0);
      plan_known(32'd100000, 1'b0, 8'sd0, 1'b0, lrbc_pkg::BarsNone, 1'b0, 1'b1,
                 1'b0, 1'b0, 31'd30000);
      // a new initial delay waits for the next up tick
      plan_write(lrbc_pkg::CSR_INITIAL_BACKOFF, 32'h3FFF_FFFF);
      plan_tick(32'd130000, 1'b0, 8'sd0);
      // zero timeout aborts on the next down tick
      plan_write(lrbc_pkg::CSR_CONNECT_TIMEOUT, 32'd0);
      plan_tick(32'd130000, 1'b0, 8'sd0);
      plan_tick(32'd130001, 1'b1, 8'sh80);
      // cap below initial: the first doubling falls to the cap
      plan_write(lrbc_pkg::CSR_MAX_BACKOFF, 32'd1);
      plan_tick(32'h8000_0000, 1'b0, 8'sd0);
      plan_tick(32'hBFFF_FFFF, 1'b0, 8'sd0);
      plan_tick(32'hBFFF_FFFF, 1'b0, 8'sd0);
      plan_tick(32'hFFFF_FFFE, 1'b0, 8'sd0);
      plan_tick(32'hFFFF_FFFE, 1'b0, 8'sd0);
      // widest timeout and cap; crossed levels, strong below fair
      plan_write(lrbc_pkg::CSR_CONNECT_TIMEOUT, 32'hFFFF_FFFF);
      plan_write(lrbc_pkg::CSR_MAX_BACKOFF, 32'h7FFF_FFFF);
      plan_write(lrbc_pkg::CSR_STRONG_LEVEL, 32'h0000_0080);
      plan_write(lrbc_pkg::CSR_FAIR_LEVEL, 32'h0000_007F);
      plan_tick(32'hFFFF_FFFF, 1'b0, 8'sd0);
      plan_tick(32'hFFFF_FFFE, 1'b0, 8'sd0);
      plan_known(32'd5, 1'b1, 8'sh80, 1'b1, lrbc_pkg::BarsStrong, 1'b1, 1'b0,
                 1'b0, 1'b0, 31'd0);
      plan_write(lrbc_pkg::CSR_STRONG_LEVEL, 32'h0000_007F);
      plan_write(lrbc_pkg::CSR_FAIR_LEVEL, 32'h0000_0080);
      plan_tick(32'd6, 1'b1, 8'sd126);
      plan_tick(32'd7, 1'b1, 8'sd127);
      plan_tick(32'd8, 1'b0, 8'sd0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // walk the directed plan; writes only once the block has drained
      writing = 1'b0;
      foreach (plan[k]) begin
         if (plan[k].kind == ROW_WRITE) begin
            if (!writing) wait_quiet();
            writing = 1'b1;
            write_reg(plan[k].reg_idx, plan[k].wdata);
         end else begin
            if (writing) end_writes();
            writing = 1'b0;
            send_tick(plan[k].tick, plan[k].has_status, plan[k].status);
            pace();
         end
      end
      if (writing) end_writes();

      // random phases: fresh settings, then runs of up and down ticks
      for (int ph = 0; ph < 11; ph++) begin
         bold    = (ph % 4 == 2);
         gaps_on = (ph % 3 != 1);
         step_hi = $urandom_range(2, 40);
         wait_quiet();

         if (bold) begin
            pick  = $urandom_range(0, 2);
            t_val = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'd1 : $urandom;
            i_val = $urandom_range(0, 1) ? 32'h3FFF_FFFF : $urandom_range(1, 32'h3FFF_FFFF);
            m_val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom_range(1, 32'h7FFF_FFFF);
         end else begin
            t_val = $urandom_range(0, 40);
            i_val = $urandom_range(1, 64);
            m_val = $urandom_range(1, 400);
         end
         s_val = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'h80 : 8'h7F)
                                          : 8'($urandom_range(0, 255));
         f_val = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'h80 : 8'h7F)
                                          : 8'($urandom_range(0, 255));
         write_reg(lrbc_pkg::CSR_CONNECT_TIMEOUT, t_val);
         write_reg(lrbc_pkg::CSR_INITIAL_BACKOFF, i_val);
         write_reg(lrbc_pkg::CSR_MAX_BACKOFF, m_val);
         if (ph == 0 || $urandom_range(0, 1) == 0) begin
            write_reg(lrbc_pkg::CSR_STRONG_LEVEL, {24'd0, s_val});
         end
         if (ph == 0 || $urandom_range(0, 1) == 0) begin
            write_reg(lrbc_pkg::CSR_FAIR_LEVEL, {24'd0, f_val});
         end
         end_writes();

         clk_ms   = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                               : $urandom;
         up_now   = $urandom_range(0, 1);
         run_left = 0;
         for (int n = 0; n < 100; n++) begin
            if (run_left == 0) begin
               up_now   = !up_now;
               run_left = up_now ? $urandom_range(1, 10) : $urandom_range(5, 60);
            end
            run_left--;

            // advance the clock; now and then jump or step back as noise
            roll = $urandom_range(0, 49);
            if (roll == 0) begin
               clk_ms = $urandom;
            end else if (roll == 1) begin
               clk_ms = clk_ms - $urandom_range(1, 50);
            end else if (bold && roll < 25) begin
               clk_ms = clk_ms + $urandom;
            end else begin
               clk_ms = clk_ms + $urandom_range(0, step_hi);
            end

            tick.now_ms  = clk_ms;
            tick.link_up = (roll == 2) ? !up_now : up_now;
            pick = $urandom_range(0, 5);
            case (pick)
               0: tick.signal_level = lvl_strong;
               1: tick.signal_level = lvl_strong - 8'sd1;
               2: tick.signal_level = lvl_fair;
               3: tick.signal_level = lvl_fair - 8'sd1;
               default: tick.signal_level = 8'($urandom_range(0, 255));
            endcase

            // hold the sender once per phase until the block has drained
            if (n == 50) wait_quiet();
            send_tick(tick, 1'b0, '0);
            pace();
         end
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("link_retry_backoff_controller regression: pass");
      end else begin
         $display("link_retry_backoff_controller regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/lrbc_pkg.sv
rtl/lrbc_chan_if.sv
rtl/link_retry_backoff_controller.sv
tb/testbench.sv
